[sv/tdtb_pkg.sv]
// Package for the tick divider and timeout bank.
// Holds the sizes, command and register codes, and the word types passed between modules.
// Depends on nothing.
package tdtb_pkg;

    localparam int NUM_PERIODIC = 4;
    localparam int NUM_TIMEOUTS = 8;
    localparam int COUNT_WIDTH  = 16;

    // Fixed field widths
    localparam int CMD_W      = 2;
    localparam int TIDX_W     = 3;
    localparam int TICKS_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FIRED_W    = 4;
    localparam int EXPIRED_W  = 8;
    localparam int NUM_DIV    = 4;

    localparam int EXP_N  = (NUM_TIMEOUTS < EXPIRED_W) ? NUM_TIMEOUTS : EXPIRED_W;
    localparam int LOAD_W = (TICKS_W + 1 > COUNT_WIDTH) ? TICKS_W + 1 : COUNT_WIDTH;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2
    } tdtb_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE = 3'd0,
        REG_DIV0   = 3'd1,
        REG_DIV1   = 3'd2,
        REG_DIV2   = 3'd3,
        REG_DIV3   = 3'd4
    } tdtb_reg_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } tdtb_cfg_t;

    typedef struct packed {
        logic              tick;
        logic              load;
        logic              clear;
        logic [TIDX_W-1:0] index;
        count_t            load_value;
    } tdtb_op_t;

endpackage

[sv/tdtb_periodic.sv]
// Periodic channels: enable and divisor registers, per-channel counts, fired mask.
// Depends on tdtb_pkg.
module tdtb_periodic (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tdtb_pkg::tdtb_cfg_t         cfg,
    input  tdtb_pkg::tdtb_op_t          op,
    output logic [tdtb_pkg::FIRED_W-1:0] fired
);
    import tdtb_pkg::*;

    logic [FIRED_W-1:0]    enable_reg, enable_next;
    logic [CFG_DATA_W-1:0] div_reg   [NUM_DIV];
    logic [CFG_DATA_W-1:0] div_next  [NUM_DIV];
    count_t                count_reg [NUM_PERIODIC];
    count_t                count_next[NUM_PERIODIC];

    always_comb
    begin
        count_t bump;
        enable_next = enable_reg;
        div_next    = div_reg;
        count_next  = count_reg;
        fired       = '0;
        bump        = '0;
        if (cfg.we)
        begin
            unique case (tdtb_reg_t'(cfg.index))
                REG_ENABLE:
                begin
                    enable_next = cfg.data[FIRED_W-1:0];
                    for (int i = 0; i < NUM_PERIODIC; i++)
                    begin
                        if (cfg.data[i] && !enable_reg[i])
                            count_next[i] = '0;
                    end
                end
                REG_DIV0: div_next[0] = cfg.data;
                REG_DIV1: div_next[1] = cfg.data;
                REG_DIV2: div_next[2] = cfg.data;
                REG_DIV3: div_next[3] = cfg.data;
                default: ;
            endcase
        end
        if (op.tick)
        begin
            for (int i = 0; i < NUM_PERIODIC; i++)
            begin
                if (enable_reg[i])
                begin
                    bump = count_reg[i] + COUNT_WIDTH'(1);
                    if (bump == COUNT_WIDTH'(div_reg[i]))
                    begin
                        fired[i] = 1'b1;
                        bump     = '0;
                    end
                    count_next[i] = bump;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
            for (int i = 0; i < NUM_DIV; i++)
                div_reg[i] <= CFG_DATA_W'(1);
            for (int i = 0; i < NUM_PERIODIC; i++)
                count_reg[i] <= '0;
        end
        else
        begin
            enable_reg <= enable_next;
            div_reg    <= div_next;
            count_reg  <= count_next;
        end
    end

endmodule

[sv/tdtb_timeout.sv]
// Timeout counters: load, clear and count down; expired mask of the updated counts.
// Depends on tdtb_pkg.
module tdtb_timeout (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tdtb_pkg::tdtb_op_t             op,
    output logic [tdtb_pkg::EXPIRED_W-1:0] expired
);
    import tdtb_pkg::*;

    count_t count_reg [NUM_TIMEOUTS];
    count_t count_next[NUM_TIMEOUTS];

    always_comb
    begin
        count_next = count_reg;
        expired    = '0;
        for (int i = 0; i < NUM_TIMEOUTS; i++)
        begin
            if (op.tick && count_reg[i] != '0)
                count_next[i] = count_reg[i] - COUNT_WIDTH'(1);
            if (op.load && int'(op.index) == i)
                count_next[i] = op.load_value;
            if (op.clear && int'(op.index) == i)
                count_next[i] = '0;
        end
        for (int i = 0; i < EXP_N; i++)
            expired[i] = (count_next[i] <= COUNT_WIDTH'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMEOUTS; i++)
                count_reg[i] <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

[sv/tick_divider_and_timeout_bank.sv]
// Top level of the tick divider and timeout bank: command decode and result word register.
// Depends on tdtb_pkg, tdtb_periodic and tdtb_timeout.
//
// One command word can be taken in every clock cycle; busy is always low. Its result word
// (fired and expired masks, after the command's update) appears on the cycle after the
// accepting edge with done high for that one cycle. All counters update in parallel in a
// single pass, so throughput is one word per cycle. The receiver cannot stall the result;
// a word not taken on its done cycle is lost.
module tick_divider_and_timeout_bank (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [tdtb_pkg::CMD_W-1:0]      cmd,
    input  logic [tdtb_pkg::TIDX_W-1:0]     timeout_index,
    input  logic [tdtb_pkg::TICKS_W-1:0]    timeout_ticks,
    input  logic                            wr_en,
    input  logic [tdtb_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [tdtb_pkg::CFG_DATA_W-1:0] wr_data,
    output logic                            done,
    output logic [tdtb_pkg::FIRED_W-1:0]    fired_mask,
    output logic [tdtb_pkg::EXPIRED_W-1:0]  expired_mask
);
    import tdtb_pkg::*;

    logic                 accept;
    tdtb_cfg_t            cfg;
    tdtb_op_t             op;
    logic [LOAD_W-1:0]    load_sum;
    logic [FIRED_W-1:0]   fired;
    logic [EXPIRED_W-1:0] expired;

    logic                 done_reg, done_next;
    logic [FIRED_W-1:0]   fired_reg;
    logic [EXPIRED_W-1:0] expired_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign cfg.we    = wr_en;
    assign cfg.index = wr_index;
    assign cfg.data  = wr_data;

    // Saturate ticks plus one at the counter maximum
    assign load_sum = LOAD_W'(timeout_ticks) + LOAD_W'(1);

    always_comb
    begin
        op.tick       = 1'b0;
        op.load       = 1'b0;
        op.clear      = 1'b0;
        op.index      = timeout_index;
        op.load_value = (load_sum > LOAD_W'({COUNT_WIDTH{1'b1}})) ? '1
                                                                    : COUNT_WIDTH'(load_sum);
        if (accept)
        begin
            unique case (tdtb_cmd_t'(cmd))
                CMD_TICK:  op.tick  = 1'b1;
                CMD_START: op.load  = 1'b1;
                CMD_STOP:  op.clear = 1'b1;
                default: ;
            endcase
        end
    end

    tdtb_periodic u_periodic (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .op    (op),
        .fired (fired)
    );

    tdtb_timeout u_timeout (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (op),
        .expired (expired)
    );

    assign done_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fired_reg   <= fired;
            expired_reg <= expired;
        end
    end

    assign done         = done_reg;
    assign fired_mask   = fired_reg;
    assign expired_mask = expired_reg;

endmodule

[sv/tdtb_checker.sv]
// Port-level checker for the tick divider and timeout bank, with its bind statement.
// Depends on tdtb_pkg and the top level's ports.
module tdtb_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic [tdtb_pkg::CMD_W-1:0]      cmd,
    input logic [tdtb_pkg::TIDX_W-1:0]     timeout_index,
    input logic [tdtb_pkg::TICKS_W-1:0]    timeout_ticks,
    input logic                            done,
    input logic [tdtb_pkg::FIRED_W-1:0]    fired_mask,
    input logic [tdtb_pkg::EXPIRED_W-1:0]  expired_mask
);
    import tdtb_pkg::*;

    logic idx_seen;

    assign idx_seen = (int'(timeout_index) < EXP_N);

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("result word missing after accepted command");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result word without accepted command");

    a_fired_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd != CMD_TICK) |=> (fired_mask == '0))
        else $error("fired mask set on a non-tick command");

    a_stop_expires: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == CMD_STOP && idx_seen)
        |=> ((expired_mask >> $past(timeout_index)) & EXPIRED_W'(1)) != '0)
        else $error("stopped timeout not shown as expired");

    // A start with zero ticks loads one, which already reads as expired.
    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == CMD_START && idx_seen && timeout_ticks != '0)
        |=> ((expired_mask >> $past(timeout_index)) & EXPIRED_W'(1)) == '0)
        else $error("started timeout shown as expired");

endmodule

bind tick_divider_and_timeout_bank tdtb_checker u_tdtb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .timeout_index (timeout_index),
    .timeout_ticks (timeout_ticks),
    .done          (done),
    .fired_mask    (fired_mask),
    .expired_mask  (expired_mask)
);
